@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define CSPU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CSPU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CSPU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cspu_pkg.sv @@
package cspu_pkg;

	localparam int ANGLE_W   = 32;
	localparam int VALUE_W   = 32;
	localparam int COEF_W    = 32;
	localparam int AQ_W      = 31;
	localparam int CFG_IDX_W = 1;

	localparam int MAG_W     = 40;
	localparam int RED_STEPS = 5;
	localparam int RED_W     = 35;
	localparam int A30_W     = 31;
	localparam int Z_W       = 32;

	// Q.32 angle constants
	localparam logic [RED_W-1:0] HALF_PI_Q32 = 35'd6746518852;
	localparam logic [RED_W-1:0] PI_Q32      = 35'd13493037705;
	localparam logic [RED_W-1:0] TWO_PI_Q32  = 35'd26986075409;

	localparam logic [63:0] A30_MAX_W = (64'(HALF_PI_Q32) + 64'd2) >> 2;
	localparam logic [A30_W-1:0] A30_MAX = A30_MAX_W[A30_W-1:0];
	localparam logic [63:0] Z_MAX_W = (A30_MAX_W * A30_MAX_W + (64'd1 << 29)) >> 30;
	localparam logic [Z_W-1:0] Z_MAX = Z_MAX_W[Z_W-1:0];

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_QUARTIC = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SEXTIC  = 1'd1;

	// coef_quartic is kept as (A+2)>>2, the Q.30 form used by the datapath
	localparam logic [AQ_W-1:0]   AQ_RESET = 31'd44739243;
	localparam logic [COEF_W-1:0] B_RESET  = 32'd5965232;

	typedef struct packed {
		logic valid;
		logic neg;
	} cspu_tag_t;

endpackage

@@ rtl/cosine_sine_polynomial_unit.sv @@
// Channel    Dir  Bits  Contents
// s_axis     in   32+1  tdata: angle Q8.24; tuser: func (0 cos, 1 sin)
// m_axis     out  32    tdata: value Q2.30
// cfg        in   1+32  index 0 coef_quartic, index 1 coef_sextic (Q0.32)
//
// One transfer per cycle in steady state while m_axis is not stalled.
// Range reduction is a chain of five compare/subtract stages against 2*pi
// multiples; the polynomial has four multiply stages, each rounded a stage later.
// A stalled m_axis holds the whole pipe in place; s_axis tready drops with it.
// arst_n clears valid bits and sets the coefficients to 1/24 and 1/720.
`include "assert_macros.svh"

module cosine_sine_polynomial_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [cspu_pkg::ANGLE_W-1:0]  s_axis_tdata,   // [31:0] angle
	input  logic                          s_axis_tuser,   // [0] func
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [cspu_pkg::VALUE_W-1:0]  m_axis_tdata,   // [31:0] value
	input  logic                          cfg_we,
	input  logic [cspu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cspu_pkg::COEF_W-1:0]   cfg_data
);

	logic                          en;
	logic [cspu_pkg::AQ_W-1:0]     coef_aq_q;
	logic [cspu_pkg::COEF_W-1:0]   coef_b_q;
	logic [cspu_pkg::COEF_W:0]     aq_sum;
	cspu_pkg::cspu_tag_t           red_tag, out_tag;
	logic [cspu_pkg::A30_W-1:0]    red_a30;

	assign en            = !out_tag.valid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_tag.valid;
	assign aq_sum        = (cspu_pkg::COEF_W+1)'(cfg_data) + (cspu_pkg::COEF_W+1)'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_aq_q <= cspu_pkg::AQ_RESET;
			coef_b_q  <= cspu_pkg::B_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cspu_pkg::REG_COEF_QUARTIC: coef_aq_q <= aq_sum[cspu_pkg::COEF_W:2];
				cspu_pkg::REG_COEF_SEXTIC:  coef_b_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	cspu_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.func     (s_axis_tuser),
		.angle    (s_axis_tdata),
		.tag_o    (red_tag),
		.a30_o    (red_a30)
	);

	cspu_poly u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_i   (red_tag),
		.a30     (red_a30),
		.coef_aq (coef_aq_q),
		.coef_b  (coef_b_q),
		.tag_o   (out_tag),
		.value   (m_axis_tdata)
	);

	`CSPU_ASSERT(a_stall_blocks_input, !(m_axis_tvalid && !m_axis_tready && s_axis_tready), "input taken while output stalled")
	`CSPU_ASSERT_NEXT(a_coef_b_write, cfg_we && (cfg_index == cspu_pkg::REG_COEF_SEXTIC), coef_b_q == $past(cfg_data), "coef_sextic write lost")

endmodule

@@ rtl/cspu_reduce.sv @@
`include "assert_macros.svh"

module cspu_reduce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic                          func,
	input  logic [cspu_pkg::ANGLE_W-1:0]  angle,
	output cspu_pkg::cspu_tag_t           tag_o,
	output logic [cspu_pkg::A30_W-1:0]    a30_o
);

	localparam int XW = cspu_pkg::MAG_W + 1;

	cspu_pkg::cspu_tag_t tag_s1, tag_s2, tag_s8, tag_s9, tag_s10;
	logic [XW-1:0]                   x_s1;
	logic [cspu_pkg::MAG_W-1:0]      mag_s2;
	logic [cspu_pkg::RED_W-2:0]      a_s8;
	logic [cspu_pkg::RED_W-3:0]      a_s9;
	logic [cspu_pkg::A30_W-1:0]      a30_s10;

	cspu_pkg::cspu_tag_t             tag_sk [cspu_pkg::RED_STEPS];
	logic [cspu_pkg::MAG_W-1:0]      rem_sk [cspu_pkg::RED_STEPS];
	cspu_pkg::cspu_tag_t             tag_in [cspu_pkg::RED_STEPS];
	logic [cspu_pkg::MAG_W-1:0]      rem_in [cspu_pkg::RED_STEPS];

	logic [XW-1:0]                   x_d;
	logic [cspu_pkg::RED_W-1:0]      rem_fin;
	logic                            ge_pi, gt_half;
	logic [cspu_pkg::A30_W+2:0]      a_rnd;

	always_comb begin
		x_d = {angle[cspu_pkg::ANGLE_W-1], angle, 8'd0};
		if (func) begin
			x_d = x_d - XW'(cspu_pkg::HALF_PI_Q32);
		end
	end

	assign rem_in[0] = mag_s2;
	assign tag_in[0] = tag_s2;

	genvar k;
	generate
		for (k = 0; k < cspu_pkg::RED_STEPS; k++) begin : g_mod
			localparam logic [cspu_pkg::MAG_W-1:0] DIV =
				cspu_pkg::MAG_W'(cspu_pkg::TWO_PI_Q32) << (cspu_pkg::RED_STEPS - 1 - k);
			if (k > 0) begin : g_link
				assign rem_in[k] = rem_sk[k-1];
				assign tag_in[k] = tag_sk[k-1];
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					tag_sk[k] <= '0;
				end else if (en) begin
					tag_sk[k] <= tag_in[k];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rem_sk[k] <= (rem_in[k] >= DIV) ? rem_in[k] - DIV : rem_in[k];
				end
			end
		end
	endgenerate

	assign rem_fin = rem_sk[cspu_pkg::RED_STEPS-1][cspu_pkg::RED_W-1:0];
	assign ge_pi   = rem_fin >= cspu_pkg::PI_Q32;
	assign gt_half = a_s8 > cspu_pkg::HALF_PI_Q32[cspu_pkg::RED_W-2:0];
	assign a_rnd   = (cspu_pkg::A30_W+3)'(a_s9) + (cspu_pkg::A30_W+3)'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			tag_s2  <= '0;
			tag_s8  <= '0;
			tag_s9  <= '0;
			tag_s10 <= '0;
		end else if (en) begin
			tag_s1  <= '{valid: in_valid, neg: 1'b0};
			tag_s2  <= tag_s1;
			tag_s8  <= '{valid: tag_sk[cspu_pkg::RED_STEPS-1].valid, neg: ge_pi};
			tag_s9  <= '{valid: tag_s8.valid, neg: tag_s8.neg ^ gt_half};
			tag_s10 <= tag_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_d;
			mag_s2  <= x_s1[XW-1] ? cspu_pkg::MAG_W'(-x_s1) : x_s1[cspu_pkg::MAG_W-1:0];
			a_s8    <= ge_pi ? (cspu_pkg::RED_W-1)'(rem_fin - cspu_pkg::PI_Q32)
			                 : rem_fin[cspu_pkg::RED_W-2:0];
			a_s9    <= gt_half
				? (cspu_pkg::RED_W-2)'(cspu_pkg::PI_Q32[cspu_pkg::RED_W-2:0] - a_s8)
				: a_s8[cspu_pkg::RED_W-3:0];
			a30_s10 <= a_rnd[cspu_pkg::A30_W+1:2];
		end
	end

	assign tag_o = tag_s10;
	assign a30_o = a30_s10;

	`CSPU_ASSERT_IMPL(a_mod_done, tag_sk[cspu_pkg::RED_STEPS-1].valid, rem_sk[cspu_pkg::RED_STEPS-1] < cspu_pkg::MAG_W'(cspu_pkg::TWO_PI_Q32), "angle not reduced below two pi")
	`CSPU_ASSERT_IMPL(a_fold_range, tag_s10.valid, a30_s10 <= cspu_pkg::A30_MAX, "folded angle above pi/2")

endmodule

@@ rtl/cspu_poly.sv @@
`include "assert_macros.svh"

module cspu_poly (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  cspu_pkg::cspu_tag_t           tag_i,
	input  logic [cspu_pkg::A30_W-1:0]    a30,
	input  logic [cspu_pkg::AQ_W-1:0]     coef_aq,
	input  logic [cspu_pkg::COEF_W-1:0]   coef_b,
	output cspu_pkg::cspu_tag_t           tag_o,
	output logic [cspu_pkg::VALUE_W-1:0]  value
);

	localparam int NST = 15;
	localparam int ZW  = cspu_pkg::Z_W;

	cspu_pkg::cspu_tag_t tag_s [1:NST];

	logic [2*cspu_pkg::A30_W-1:0] sq_s1;
	logic [ZW-1:0]  z_s2, z_s3, z_s4, z_s5, z_s6, z_s7, z_s8, z_s9, z_s10;
	logic [63:0]    bz_s3;
	logic [32:0]    bzr_s4;
	logic [33:0]    t_s5;
	logic [32:0]    tm_s6;
	logic           ts_s6, ts_s7;
	logic [64:0]    zt_s7;
	logic [35:0]    ztr_s8;
	logic           ts_s8;
	logic [36:0]    u_s9;
	logic [35:0]    um_s10;
	logic           us_s10, us_s11, us_s12;
	logic [67:0]    zu_s11;
	logic [38:0]    zur_s12;
	logic signed [39:0] r_s13, rw_s14;
	logic [cspu_pkg::VALUE_W-1:0] v_s15;

	logic [62:0]    sq_rnd;
	logic [64:0]    bz_rnd;
	logic [65:0]    zt_rnd;
	logic [68:0]    zu_rnd;
	logic signed [39:0] v_neg;

	assign sq_rnd = 63'(sq_s1) + (63'd1 << 29);
	assign bz_rnd = 65'(bz_s3) + (65'd1 << 31);
	assign zt_rnd = 66'(zt_s7) + (66'd1 << 29);
	assign zu_rnd = 69'(zu_s11) + (69'd1 << 29);
	assign v_neg  = tag_s[14].neg ? -rw_s14 : rw_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NST; i++) begin
				tag_s[i] <= '0;
			end
		end else if (en) begin
			tag_s[1] <= tag_i;
			for (int i = 2; i <= NST; i++) begin
				tag_s[i] <= tag_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1   <= 62'(a30) * 62'(a30);
			z_s2    <= sq_rnd[61:30];
			bz_s3   <= 64'(coef_b) * 64'(z_s2);
			z_s3    <= z_s2;
			bzr_s4  <= bz_rnd[64:32];
			z_s4    <= z_s3;
			t_s5    <= 34'(coef_aq) - 34'(bzr_s4);
			z_s5    <= z_s4;
			tm_s6   <= t_s5[33] ? 33'(-t_s5) : t_s5[32:0];
			ts_s6   <= t_s5[33];
			z_s6    <= z_s5;
			zt_s7   <= 65'(z_s6) * 65'(tm_s6);
			ts_s7   <= ts_s6;
			z_s7    <= z_s6;
			ztr_s8  <= zt_rnd[65:30];
			ts_s8   <= ts_s7;
			z_s8    <= z_s7;
			u_s9    <= ts_s8 ? 37'd0 - 37'(ztr_s8) - (37'd1 << 29)
			                 : 37'(ztr_s8) - (37'd1 << 29);
			z_s9    <= z_s8;
			um_s10  <= u_s9[36] ? 36'(-u_s9) : u_s9[35:0];
			us_s10  <= u_s9[36];
			z_s10   <= z_s9;
			zu_s11  <= 68'(z_s10) * 68'(um_s10);
			us_s11  <= us_s10;
			zur_s12 <= zu_rnd[68:30];
			us_s12  <= us_s11;
			r_s13   <= us_s12 ? (40'sd1 <<< 30) - signed'(40'(zur_s12))
			                  : (40'sd1 <<< 30) + signed'(40'(zur_s12));
			rw_s14  <= (r_s13 > (40'sd1 <<< 30)) ? r_s13 - (40'sd1 <<< 31) : r_s13;
			if (v_neg > 40'sd2147483647) begin
				v_s15 <= 32'h7FFF_FFFF;
			end else if (v_neg < -40'sd2147483648) begin
				v_s15 <= 32'h8000_0000;
			end else begin
				v_s15 <= v_neg[31:0];
			end
		end
	end

	assign tag_o = tag_s[NST];
	assign value = v_s15;

	`CSPU_ASSERT_IMPL(a_z_range, tag_s[2].valid, z_s2 <= cspu_pkg::Z_MAX, "square of folded angle out of range")
	`CSPU_ASSERT_IMPL(a_t_mag, tag_s[6].valid, tm_s6 <= (33'd1 << 32), "inner term magnitude too large")

endmodule
